[rtl/epsc_pkg.sv]
// Shared types, constants and calendar tables for the epoch seconds to calendar unit.
// Used by epsc_ctrl, epsc_dp and epoch_seconds_to_calendar_unit.
// Depends on nothing.
package epsc_pkg;

    localparam int unsigned SecsWidth    = 32;
    localparam int unsigned DayWidth     = 16;
    localparam int unsigned YearWidth    = 12;
    localparam int unsigned MonthWidth   = 4;
    localparam int unsigned MdayWidth    = 5;
    localparam int unsigned HourWidth    = 5;
    localparam int unsigned MinuteWidth  = 6;
    localparam int unsigned CntWidth     = 1;

    localparam logic [SecsWidth-1:0] DaySecs       = SecsWidth'(86400);
    localparam logic [SecsWidth-1:0] HourSecs      = SecsWidth'(3600);
    localparam logic [SecsWidth-1:0] MinuteSecs    = SecsWidth'(60);

    // Rounded-up reciprocals of 675, 225 and 15, the odd parts of the three divisors.
    // The scales 2^35, 2^21 and 2^14 keep each quotient exact over its input range.
    localparam logic [25:0]          DayRecip      = 26'd50903317;
    localparam logic [13:0]          HourRecip     = 14'd9321;
    localparam logic [10:0]          MinuteRecip   = 11'd1093;

    // Each division takes a quotient step and then a remainder step.
    localparam logic [CntWidth-1:0]  DivSteps      = CntWidth'(1);

    localparam logic [YearWidth-1:0] BaseYear      = YearWidth'(1970);
    localparam logic [6:0]           BaseYearMod100 = 7'd70;
    localparam logic [8:0]           BaseYearMod400 = 9'd370;
    localparam logic [8:0]           LeapYearDays   = 9'd366;
    localparam logic [8:0]           CommonYearDays = 9'd365;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MINUTE
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_init;
        div_sel_t div_sel;
        logic     div_step;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic year_fits;
        logic month_fits;
    } status_t;

    function automatic logic [MdayWidth-1:0] month_len(input logic [MonthWidth-1:0] m,
                                                       input logic leap);
        logic [MdayWidth-1:0] len;
        begin
            case (m)
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd30;
                4'd5:    len = 5'd30;
                4'd8:    len = 5'd30;
                4'd10:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

[rtl/epsc_ctrl.sv]
// Controller state machine for the epoch seconds to calendar unit.
// Sequences the divider, the year walk and the month walk; owns the output valid flag.
// Depends on epsc_pkg.
module epsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  epsc_pkg::status_t status,
    output epsc_pkg::cmd_t    cmd
);
    import epsc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (status.div_last)
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (status.div_last)
                begin
                    state_next = ST_MINUTE;
                end
            end
            ST_MINUTE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (status.year_fits)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (status.month_fits)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.div_sel   = DIV_DAY;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
            end
            ST_DAY:
            begin
                cmd.div_step = 1'b1;
                cmd.div_init = status.div_last;
                cmd.div_sel  = DIV_HOUR;
            end
            ST_HOUR:
            begin
                cmd.div_step = 1'b1;
                cmd.div_init = status.div_last;
                cmd.div_sel  = DIV_MINUTE;
            end
            ST_MINUTE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_YEAR:
            begin
                cmd.year_step = !status.year_fits;
            end
            ST_MONTH:
            begin
                cmd.month_step = !status.month_fits;
            end
            ST_FINISH:
            begin
                cmd.out_load = out_free;
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[rtl/epsc_dp.sv]
// Datapath for the epoch seconds to calendar unit: reciprocal-multiply dividers by
// constants, year and month walkers, and the output word register. Depends on epsc_pkg.
module epsc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [epsc_pkg::SecsWidth-1:0]     epoch_seconds,
    input  epsc_pkg::cmd_t                     cmd,
    output epsc_pkg::status_t                  status,
    output logic [31:0]                        out_word
);
    import epsc_pkg::*;

    logic [SecsWidth-1:0]   rem_reg,  rem_next;
    logic [DayWidth-1:0]    quo_reg,  quo_next;
    logic [CntWidth-1:0]    cnt_reg,  cnt_next;
    div_sel_t               sel_reg,  sel_next;
    logic [DayWidth-1:0]    day_reg,  day_next;
    logic [HourWidth-1:0]   hour_reg, hour_next;
    logic [MinuteWidth-1:0] min_reg,  min_next;
    logic [YearWidth-1:0]   year_reg, year_next;
    logic [6:0]             mod100_reg, mod100_next;
    logic [8:0]             mod400_reg, mod400_next;
    logic [MonthWidth-1:0]  month_reg, month_next;
    logic [31:0]            out_reg;

    logic [50:0]            day_prod;
    logic [26:0]            hour_prod;
    logic [20:0]            min_prod;
    logic [DayWidth-1:0]    quo_calc;
    logic [SecsWidth-1:0]   quo_times_div;
    logic                   leap;
    logic [8:0]             ylen;
    logic [MdayWidth-1:0]   mlen;

    // The power-of-two part of each divisor is shifted out first; the remainder
    // that is divided is below 2^32, 86400 and 3600 in turn.
    assign day_prod  = 51'(rem_reg[SecsWidth-1:7]) * 51'(DayRecip);
    assign hour_prod = 27'(rem_reg[16:4]) * 27'(HourRecip);
    assign min_prod  = 21'(rem_reg[11:2]) * 21'(MinuteRecip);

    always_comb
    begin
        case (sel_reg)
            DIV_HOUR:
            begin
                quo_calc      = DayWidth'(hour_prod[26:21]);
                quo_times_div = SecsWidth'(quo_reg[HourWidth-1:0]) * HourSecs;
            end
            DIV_MINUTE:
            begin
                quo_calc      = DayWidth'(min_prod[20:14]);
                quo_times_div = SecsWidth'(quo_reg[MinuteWidth-1:0]) * MinuteSecs;
            end
            default:
            begin
                quo_calc      = day_prod[50:35];
                quo_times_div = SecsWidth'(quo_reg) * DaySecs;
            end
        endcase
    end

    // Gregorian rule from the year's residues, kept as running counters.
    assign leap = ((year_reg[1:0] == 2'b00) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign ylen = leap ? LeapYearDays : CommonYearDays;
    assign mlen = month_len(month_reg, leap);

    assign status.div_last   = (cnt_reg == '0);
    assign status.year_fits  = ({1'b0, day_reg} < {8'd0, ylen});
    assign status.month_fits = (day_reg < {11'd0, mlen});

    assign out_word = out_reg;

    always_comb
    begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        year_next   = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;

        if (cmd.div_step)
        begin
            cnt_next = cnt_reg - CntWidth'(1);
            if (cnt_reg == '0)
            begin
                rem_next = rem_reg - quo_times_div;
                case (sel_reg)
                    DIV_DAY:    day_next  = quo_reg;
                    DIV_HOUR:   hour_next = quo_reg[HourWidth-1:0];
                    DIV_MINUTE: min_next  = quo_reg[MinuteWidth-1:0];
                    default:    day_next  = day_reg;
                endcase
            end
            else
            begin
                quo_next = quo_calc;
            end
        end

        if (cmd.load)
        begin
            rem_next    = epoch_seconds;
            year_next   = BaseYear;
            mod100_next = BaseYearMod100;
            mod400_next = BaseYearMod400;
            month_next  = '0;
        end

        if (cmd.load || cmd.div_init)
        begin
            quo_next = '0;
            cnt_next = DivSteps;
            sel_next = cmd.load ? DIV_DAY : cmd.div_sel;
        end

        if (cmd.year_step)
        begin
            day_next    = day_reg - {7'd0, ylen};
            year_next   = year_reg + YearWidth'(1);
            mod100_next = (mod100_reg == 7'd99)  ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end

        if (cmd.month_step)
        begin
            day_next   = day_reg - {11'd0, mlen};
            month_next = month_reg + MonthWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sel_reg <= DIV_DAY;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
        if (cmd.out_load)
        begin
            out_reg <= {min_reg, hour_reg, day_reg[MdayWidth-1:0] + MdayWidth'(1),
                        month_reg, year_reg};
        end
    end

endmodule

[rtl/epoch_seconds_to_calendar_unit.sv]
// Top level of the epoch seconds to calendar unit.
// Joins the controller epsc_ctrl and the datapath epsc_dp; depends on epsc_pkg.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one word: a 32-bit
//   unsigned count of seconds since 1970-01-01 00:00. The master channel
//   (m_tvalid, m_tready, m_tdata) returns one word per input with the
//   Gregorian year, month index (0 is January), day of month, hour and minute.
//   Seconds within the minute are dropped.
//
//   Each word passes through division (day, hour and minute, each a
//   reciprocal multiply and a remainder step), a walk of one year at a
//   time from 1970 (up to 136 years), a walk of one month at a time (up
//   to 11 months) and a handoff to the output register, after which
//   m_tvalid rises and s_tready returns. The year walk is the longest part.
//   One word is worked on at a time; s_tready is high only while the unit is free.
//
//   The result sits in an output register, so a new input word is accepted
//   while the previous result still waits on m_tready. If the receiver stalls
//   longer, the finished result waits in the unit until the register frees.
//   Reset clears the controller, divider count and select, dropping any word
//   in flight; other datapath state is not reset. There is no configuration.
module epoch_seconds_to_calendar_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [11:0] year, [15:12] month_index,
                                   // [20:16] day_of_month, [25:21] hour, [31:26] minute
);
    import epsc_pkg::*;

    cmd_t    cmd;
    status_t status;

    epsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epsc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch_seconds (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .out_word      (m_tdata)
    );

    // A taken word makes the unit busy, so s_tready drops after the handshake.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while the previous word was still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] <= 4'd11))
        else $error("month index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[20:16] != 5'd0) && (m_tdata[25:21] <= 5'd23)))
        else $error("day of month or hour out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (status.month_fits && status.year_fits))
        else $error("result loaded before the month walk finished");

endmodule
